// ===== rtl/core/rtd_code_to_temperature_defines.svh =====
// Assertion macros shared by the RTD converter modules.
// They expand to nothing when SYNTH is defined.
`ifndef RTD_CODE_TO_TEMPERATURE_DEFINES_SVH
`define RTD_CODE_TO_TEMPERATURE_DEFINES_SVH

`ifndef SYNTH

`define RTD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define RTD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RTD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define RTD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/rtd_c2t_pkg.sv =====
package rtd_c2t_pkg;

	localparam int TABLE_ENTRIES_DEF = 101;
	localparam int CODE_BITS_DEF = 12;
	localparam int ROM_LEN = 101;
	localparam int IDX_W = $clog2(ROM_LEN);

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_FORMULA_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ADC_LOW = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ADC_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_R_MIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_GAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SEG_WIDTH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SEG_RECIP = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_V_UPPER = 3'd7;

	localparam logic [1:0] ST_VALID = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER = 2'd2;

	localparam logic [17:0] VOFF = 18'd6554;
	localparam logic [31:0] VGAIN_RECIP = 32'd3192207;
	localparam logic [23:0] RES_MAX = 24'hFF_FFFF;
	localparam logic [24:0] TEMP_MAX = 25'h1FF_FFFF;

	typedef struct packed {
		logic [11:0] adc_code;
		logic [17:0] voltage;
	} rtd_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [23:0] resistance;
		logic [24:0] temperature;
	} rtd_out_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [23:0] resistance;
		logic [23:0] delta;
	} rtd_res_t;

	typedef struct packed {
		logic        formula_mode;
		logic [11:0] adc_low;
		logic [11:0] adc_high;
		logic [23:0] r_min;
		logic [31:0] code_gain;
		logic [23:0] seg_width;
		logic [31:0] seg_recip;
		logic [17:0] v_upper;
	} rtd_cfg_t;

	localparam rtd_cfg_t CFG_RESET = '{
		formula_mode: 1'b0,
		adc_low:      12'd0,
		adc_high:     12'd4095,
		r_min:        24'd6553600,
		code_gain:    32'd459068,
		seg_width:    24'd73433,
		seg_recip:    32'd58489,
		v_upper:      18'd157286
	};

	localparam logic [24:0] TEMP_ROM [ROM_LEN] = '{
		25'd0,        25'd187962,   25'd376094,   25'd564386,   25'd752838,
		25'd941451,   25'd1130227,  25'd1319161,  25'd1508259,  25'd1697520,
		25'd1886945,  25'd2076528,  25'd2266281,  25'd2456198,  25'd2646278,
		25'd2836523,  25'd3026931,  25'd3217503,  25'd3408246,  25'd3599158,
		25'd3790235,  25'd3981476,  25'd4172887,  25'd4364468,  25'd4556220,
		25'd4748136,  25'd4940228,  25'd5132485,  25'd5324911,  25'd5517515,
		25'd5710289,  25'd5903234,  25'd6096349,  25'd6289641,  25'd6483103,
		25'd6676742,  25'd6870532,  25'd7064519,  25'd7258702,  25'd7453016,
		25'd7647527,  25'd7842234,  25'd8037138,  25'd8232174,  25'd8427405,
		25'd8622768,  25'd8818393,  25'd9014149,  25'd9210102,  25'd9406185,
		25'd9602531,  25'd9799008,  25'd9995682,  25'd10192552, 25'd10389553,
		25'd10586817, 25'd10784211, 25'd10981802, 25'd11179524, 25'd11377508,
		25'd11575689, 25'd11774001, 25'd11972510, 25'd12171215, 25'd12370117,
		25'd12569215, 25'd12768510, 25'd12967936, 25'd13167624, 25'd13367443,
		25'd13567525, 25'd13767737, 25'd13968146, 25'd14168818, 25'd14369620,
		25'd14570619, 25'd14771814, 25'd14973207, 25'd15174795, 25'd15376581,
		25'd15578563, 25'd15780807, 25'd15983182, 25'd16185754, 25'd16388522,
		25'd16591553, 25'd16794714, 25'd16998072, 25'd17201693, 25'd17405510,
		25'd17609458, 25'd17813668, 25'd18018075, 25'd18222678, 25'd18427544,
		25'd18632540, 25'd18837799, 25'd19043189, 25'd19248841, 25'd19454689,
		25'd19660800
	};

endpackage

// ===== rtl/core/rtd_c2t_res.sv =====
`include "rtd_code_to_temperature_defines.svh"

module rtd_c2t_res import rtd_c2t_pkg::*; #(
	parameter int CODE_BITS = CODE_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  rtd_cfg_t cfg,
	input  logic     in_valid,
	output logic     in_ready,
	input  rtd_in_t  in_item,
	output logic     out_valid,
	input  logic     out_ready,
	output rtd_res_t out_item
);

	localparam int USED_BITS = (CODE_BITS < 12) ? CODE_BITS : 12;
	localparam logic [11:0] CODE_MASK = ~(~12'd0 << USED_BITS);

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	logic [11:0] code_c;
	logic [1:0]  status_c;
	logic [17:0] opa_c;
	logic [31:0] opb_c;

	logic [1:0]  status_s1;
	logic        mode_s1;
	logic [17:0] opa_s1;
	logic [31:0] opb_s1;

	logic [1:0]  status_s2;
	logic        mode_s2;
	logic [49:0] prod_s2;

	logic [50:0] rnd8_c, rnd16_c;
	logic [42:0] delta_c;
	logic [43:0] sum_c;
	logic [23:0] r_c;

	rtd_res_t item_s3;

	assign en_s3 = !v_s3 || out_ready;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// Range check and operand selection for the single shared multiplier.
	always_comb begin
		code_c = in_item.adc_code & CODE_MASK;
		status_c = ST_VALID;
		opa_c = '0;
		opb_c = '0;
		if (!cfg.formula_mode) begin
			if (code_c < cfg.adc_low) begin
				status_c = ST_UNDER;
			end else if (code_c > cfg.adc_high) begin
				status_c = ST_OVER;
			end else begin
				opa_c = 18'(code_c - cfg.adc_low);
				opb_c = cfg.code_gain;
			end
		end else begin
			if (in_item.voltage < VOFF) begin
				status_c = ST_UNDER;
			end else if (in_item.voltage > cfg.v_upper) begin
				status_c = ST_OVER;
			end else begin
				opa_c = in_item.voltage - VOFF;
				opb_c = VGAIN_RECIP;
			end
		end
	end

	always_comb begin
		rnd8_c = {1'b0, prod_s2} + 51'd128;
		rnd16_c = {1'b0, prod_s2} + 51'd32768;
		delta_c = mode_s2 ? 43'(rnd16_c >> 16) : 43'(rnd8_c >> 8);
		sum_c = 44'(cfg.r_min) + 44'(delta_c);
		r_c = (sum_c > 44'(RES_MAX)) ? RES_MAX : sum_c[23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			status_s1 <= status_c;
			mode_s1 <= cfg.formula_mode;
			opa_s1 <= opa_c;
			opb_s1 <= opb_c;
		end
		if (en_s2) begin
			status_s2 <= status_s1;
			mode_s2 <= mode_s1;
			prod_s2 <= {32'b0, opa_s1} * {18'b0, opb_s1};
		end
		if (en_s3) begin
			item_s3.status <= status_s2;
			if (status_s2 == ST_VALID) begin
				item_s3.resistance <= r_c;
				item_s3.delta <= r_c - cfg.r_min;
			end else begin
				item_s3.resistance <= '0;
				item_s3.delta <= '0;
			end
		end
	end

	assign out_valid = v_s3;
	assign out_item = item_s3;

	`RTD_ASSERT_NXT(a_res_enter, clk, arst_n, in_valid && in_ready, v_s1, "accepted item lost")
	`RTD_ASSERT_IMP(a_res_reject_zero, clk, arst_n, v_s3 && (item_s3.status != ST_VALID), (item_s3.resistance == '0) && (item_s3.delta == '0), "rejected item carries data")
	`RTD_ASSERT_IMP(a_res_floor, clk, arst_n, v_s3 && (item_s3.status == ST_VALID), item_s3.resistance >= cfg.r_min, "resistance below r_min")

endmodule

// ===== rtl/core/rtd_c2t_interp.sv =====
`include "rtd_code_to_temperature_defines.svh"

module rtd_c2t_interp import rtd_c2t_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  rtd_cfg_t cfg,
	input  logic     in_valid,
	output logic     in_ready,
	input  rtd_res_t in_item,
	output logic     out_valid,
	input  logic     out_ready,
	output rtd_out_t out_item
);

	localparam int LAST_INT = ((TABLE_ENTRIES < ROM_LEN) ? TABLE_ENTRIES : ROM_LEN) - 2;
	localparam logic [IDX_W-1:0] LAST_SEG = IDX_W'(LAST_INT);

	logic v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic en_s4, en_s5, en_s6, en_s7, en_s8, en_s9, en_s10;

	logic [1:0]  status_s4, status_s5, status_s6, status_s7, status_s8, status_s9;
	logic [23:0] r_s4, r_s5, r_s6, r_s7, r_s8, r_s9;
	logic [23:0] d_s4, d_s5;
	logic [23:0] pidx_s4;
	logic [IDX_W-1:0] idx_c, idx_s5, idx_s6, idx_s7;
	logic [30:0] base_s5;
	logic [23:0] rem_s6;
	logic [39:0] fr_s7;
	logic [31:0] frac_s8;
	logic [24:0] lo_s8, diff_s8, lo_s9;
	logic [56:0] tprod_s9;

	logic [55:0] pprod_c, fprod_c;
	logic [57:0] tsum_c;
	logic [42:0] tval_c;
	logic [24:0] t_c;

	rtd_out_t out_s10;

	assign en_s10 = !v_s10 || out_ready;
	assign en_s9 = !v_s9 || en_s10;
	assign en_s8 = !v_s8 || en_s9;
	assign en_s7 = !v_s7 || en_s8;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign in_ready = en_s4;

	always_comb begin
		pprod_c = {32'b0, in_item.delta} * {24'b0, cfg.seg_recip};
		idx_c = (pidx_s4 > 24'(LAST_SEG)) ? LAST_SEG : pidx_s4[IDX_W-1:0];
		fprod_c = {32'b0, rem_s6} * {24'b0, cfg.seg_recip};
		tsum_c = {1'b0, tprod_s9} + 58'd32768;
		tval_c = 43'(lo_s9) + 43'(tsum_c[57:16]);
		t_c = (tval_c > 43'(TEMP_MAX)) ? TEMP_MAX : tval_c[24:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			if (en_s4) begin
				v_s4 <= in_valid;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
			if (en_s6) begin
				v_s6 <= v_s5;
			end
			if (en_s7) begin
				v_s7 <= v_s6;
			end
			if (en_s8) begin
				v_s8 <= v_s7;
			end
			if (en_s9) begin
				v_s9 <= v_s8;
			end
			if (en_s10) begin
				v_s10 <= v_s9;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			status_s4 <= in_item.status;
			r_s4 <= in_item.resistance;
			d_s4 <= in_item.delta;
			pidx_s4 <= pprod_c[55:32];
		end
		if (en_s5) begin
			status_s5 <= status_s4;
			r_s5 <= r_s4;
			d_s5 <= d_s4;
			idx_s5 <= idx_c;
			base_s5 <= {24'b0, idx_c} * {7'b0, cfg.seg_width};
		end
		if (en_s6) begin
			status_s6 <= status_s5;
			r_s6 <= r_s5;
			idx_s6 <= idx_s5;
			// A segment base past the offset leaves no remainder.
			if ({7'b0, d_s5} >= base_s5) begin
				rem_s6 <= 24'({7'b0, d_s5} - base_s5);
			end else begin
				rem_s6 <= '0;
			end
		end
		if (en_s7) begin
			status_s7 <= status_s6;
			r_s7 <= r_s6;
			idx_s7 <= idx_s6;
			fr_s7 <= fprod_c[55:16];
		end
		if (en_s8) begin
			status_s8 <= status_s7;
			r_s8 <= r_s7;
			frac_s8 <= (|fr_s7[39:32]) ? 32'hFFFF_FFFF : fr_s7[31:0];
			lo_s8 <= TEMP_ROM[idx_s7];
			diff_s8 <= TEMP_ROM[idx_s7 + IDX_W'(1)] - TEMP_ROM[idx_s7];
		end
		if (en_s9) begin
			status_s9 <= status_s8;
			r_s9 <= r_s8;
			lo_s9 <= lo_s8;
			tprod_s9 <= {25'b0, frac_s8} * {32'b0, diff_s8};
		end
		if (en_s10) begin
			out_s10.status <= status_s9;
			out_s10.resistance <= r_s9;
			out_s10.temperature <= (status_s9 == ST_VALID) ? t_c : '0;
		end
	end

	assign out_valid = v_s10;
	assign out_item = out_s10;

	`RTD_ASSERT_IMP(a_int_idx_range, clk, arst_n, v_s5, idx_s5 <= LAST_SEG, "segment index past table")
	`RTD_ASSERT_NXT(a_int_advance, clk, arst_n, v_s9 && en_s10, v_s10, "item dropped at output stage")
	`RTD_ASSERT_IMP(a_int_reject_zero, clk, arst_n, v_s10 && (out_s10.status != ST_VALID), (out_s10.temperature == '0) && (out_s10.resistance == '0), "rejected item carries data")

endmodule

// ===== rtl/core/rtd_code_to_temperature.sv =====
// Converts one RTD reading per item into a resistance (Q8.16 ohms) and a
// temperature (Q9.16 C) by range check, two-point or transfer-function scaling,
// and linear interpolation over a fixed 101-entry table spanning 0 to 300 C.
// The block takes one item every clock cycle while the output does not stall;
// its result passes through the ten register stages of the datapath, each of
// which holds at most one multiplier. Backpressure on the output stalls only
// as far back as the pipeline is full, so bubbles are squeezed out before the
// input is held off. Configuration registers are written through the plain
// write port and must only change while no item is in flight.
module rtd_code_to_temperature import rtd_c2t_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int CODE_BITS = CODE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rtd_in_t               in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rtd_out_t              out_item
);

	rtd_cfg_t cfg_q;

	logic     res_valid;
	logic     res_ready;
	rtd_res_t res_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_FORMULA_MODE: cfg_q.formula_mode <= cfg_wdata[0];
				CFG_ADC_LOW:      cfg_q.adc_low <= cfg_wdata[11:0];
				CFG_ADC_HIGH:     cfg_q.adc_high <= cfg_wdata[11:0];
				CFG_R_MIN:        cfg_q.r_min <= cfg_wdata[23:0];
				CFG_CODE_GAIN:    cfg_q.code_gain <= cfg_wdata[31:0];
				CFG_SEG_WIDTH:    cfg_q.seg_width <= cfg_wdata[23:0];
				CFG_SEG_RECIP:    cfg_q.seg_recip <= cfg_wdata[31:0];
				CFG_V_UPPER:      cfg_q.v_upper <= cfg_wdata[17:0];
				default: begin
				end
			endcase
		end
	end

	rtd_c2t_res #(
		.CODE_BITS(CODE_BITS)
	) u_res (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (res_valid),
		.out_ready (res_ready),
		.out_item  (res_item)
	);

	rtd_c2t_interp #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (res_valid),
		.in_ready  (res_ready),
		.in_item   (res_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== verif/rtd_code_to_temperature_checker.sv =====
`timescale 1ns / 1ps
module rtd_code_to_temperature_checker import rtd_c2t_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  rtd_in_t               in_item,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  rtd_out_t              out_item,
	output int                    mismatches,
	output int                    results_pending
);

	localparam int TEMP_POINTS = 101;
	localparam int PT_W = $clog2(TEMP_POINTS);
	localparam logic [63:0] LAST_SEG = 64'(TEMP_POINTS - 2);
	localparam logic [63:0] VOLT_OFFSET = 64'd6554;
	localparam logic [63:0] TRANSFER_GAIN = 64'd3192207;
	localparam logic [63:0] RES_LIMIT = 64'hFF_FFFF;
	localparam logic [63:0] TEMP_LIMIT = 64'h1FF_FFFF;
	localparam logic [63:0] FRAC_LIMIT = 64'hFFFF_FFFF;

	localparam rtd_cfg_t SETTINGS_AT_RESET = '{
		formula_mode: 1'b0,
		adc_low:      12'd0,
		adc_high:     12'd4095,
		r_min:        24'd6553600,
		code_gain:    32'd459068,
		seg_width:    24'd73433,
		seg_recip:    32'd58489,
		v_upper:      18'd157286
	};

	localparam logic [24:0] DEG_TABLE [TEMP_POINTS] = '{
		25'd0,        25'd187962,   25'd376094,   25'd564386,   25'd752838,
		25'd941451,   25'd1130227,  25'd1319161,  25'd1508259,  25'd1697520,
		25'd1886945,  25'd2076528,  25'd2266281,  25'd2456198,  25'd2646278,
		25'd2836523,  25'd3026931,  25'd3217503,  25'd3408246,  25'd3599158,
		25'd3790235,  25'd3981476,  25'd4172887,  25'd4364468,  25'd4556220,
		25'd4748136,  25'd4940228,  25'd5132485,  25'd5324911,  25'd5517515,
		25'd5710289,  25'd5903234,  25'd6096349,  25'd6289641,  25'd6483103,
		25'd6676742,  25'd6870532,  25'd7064519,  25'd7258702,  25'd7453016,
		25'd7647527,  25'd7842234,  25'd8037138,  25'd8232174,  25'd8427405,
		25'd8622768,  25'd8818393,  25'd9014149,  25'd9210102,  25'd9406185,
		25'd9602531,  25'd9799008,  25'd9995682,  25'd10192552, 25'd10389553,
		25'd10586817, 25'd10784211, 25'd10981802, 25'd11179524, 25'd11377508,
		25'd11575689, 25'd11774001, 25'd11972510, 25'd12171215, 25'd12370117,
		25'd12569215, 25'd12768510, 25'd12967936, 25'd13167624, 25'd13367443,
		25'd13567525, 25'd13767737, 25'd13968146, 25'd14168818, 25'd14369620,
		25'd14570619, 25'd14771814, 25'd14973207, 25'd15174795, 25'd15376581,
		25'd15578563, 25'd15780807, 25'd15983182, 25'd16185754, 25'd16388522,
		25'd16591553, 25'd16794714, 25'd16998072, 25'd17201693, 25'd17405510,
		25'd17609458, 25'd17813668, 25'd18018075, 25'd18222678, 25'd18427544,
		25'd18632540, 25'd18837799, 25'd19043189, 25'd19248841, 25'd19454689,
		25'd19660800
	};

	rtd_cfg_t settings = SETTINGS_AT_RESET;
	rtd_out_t readings_due [$];
	rtd_out_t want;
	rtd_out_t got;

	function automatic logic [24:0] interpolate_temp(rtd_cfg_t s, logic [23:0] res);
		logic [63:0] d;
		logic [63:0] seg;
		logic [63:0] base;
		logic [63:0] rem;
		logic [63:0] frac;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] t;
		logic [PT_W-1:0] pos;
		d = 64'd0;
		if (res >= s.r_min) begin
			d = 64'(res) - 64'(s.r_min);
		end
		seg = (d * 64'(s.seg_recip)) >> 32;
		if (seg > LAST_SEG) begin
			seg = LAST_SEG;
		end
		base = seg * 64'(s.seg_width);
		rem = (d >= base) ? d - base : 64'd0;
		frac = (rem * 64'(s.seg_recip)) >> 16;
		if (frac > FRAC_LIMIT) begin
			frac = FRAC_LIMIT;
		end
		pos = seg[PT_W-1:0];
		lo = 64'(DEG_TABLE[pos]);
		hi = 64'(DEG_TABLE[pos + PT_W'(1)]);
		t = lo + ((frac * (hi - lo) + 64'd32768) >> 16);
		return (t > TEMP_LIMIT) ? TEMP_LIMIT[24:0] : t[24:0];
	endfunction

	function automatic rtd_out_t convert_reading(rtd_cfg_t s, rtd_in_t rd);
		rtd_out_t o;
		logic [63:0] span;
		logic [63:0] delta;
		logic [63:0] sum;
		o = '0;
		o.status = ST_VALID;
		delta = 64'd0;
		if (!s.formula_mode) begin
			if (rd.adc_code < s.adc_low) begin
				o.status = ST_UNDER;
			end else if (rd.adc_code > s.adc_high) begin
				o.status = ST_OVER;
			end else begin
				span = 64'(rd.adc_code - s.adc_low);
				delta = (span * 64'(s.code_gain) + 64'd128) >> 8;
			end
		end else begin
			if (64'(rd.voltage) < VOLT_OFFSET) begin
				o.status = ST_UNDER;
			end else if (rd.voltage > s.v_upper) begin
				o.status = ST_OVER;
			end else begin
				span = 64'(rd.voltage) - VOLT_OFFSET;
				delta = (span * TRANSFER_GAIN + 64'd32768) >> 16;
			end
		end
		if (o.status == ST_VALID) begin
			sum = 64'(s.r_min) + delta;
			o.resistance = (sum > RES_LIMIT) ? RES_LIMIT[23:0] : sum[23:0];
			o.temperature = interpolate_temp(s, o.resistance);
		end
		return o;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			settings = SETTINGS_AT_RESET;
			readings_due.delete();
		end else begin
			if (out_valid && out_ready) begin
				got = out_item;
				if (readings_due.size() == 0) begin
					$display("%0t: expected no item, got %0d %0d %0d",
						$time, got.status, got.resistance, got.temperature);
					mismatches++;
				end else begin
					want = readings_due.pop_front();
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
						mismatches++;
					end
					if (got.resistance !== want.resistance) begin
						$display("%0t: resistance expected %0d, got %0d",
							$time, want.resistance, got.resistance);
						mismatches++;
					end
					if (got.temperature !== want.temperature) begin
						$display("%0t: temperature expected %0d, got %0d",
							$time, want.temperature, got.temperature);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				readings_due.push_back(convert_reading(settings, in_item));
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_FORMULA_MODE: settings.formula_mode = cfg_wdata[0];
					CFG_ADC_LOW:      settings.adc_low = cfg_wdata[11:0];
					CFG_ADC_HIGH:     settings.adc_high = cfg_wdata[11:0];
					CFG_R_MIN:        settings.r_min = cfg_wdata[23:0];
					CFG_CODE_GAIN:    settings.code_gain = cfg_wdata;
					CFG_SEG_WIDTH:    settings.seg_width = cfg_wdata[23:0];
					CFG_SEG_RECIP:    settings.seg_recip = cfg_wdata;
					CFG_V_UPPER:      settings.v_upper = cfg_wdata[17:0];
					default: ;
				endcase
			end
		end
		results_pending <= readings_due.size();
	end

endmodule

// ===== verif/rtd_code_to_temperature_tb.sv =====
`timescale 1ns / 1ps
module rtd_code_to_temperature_tb;
	import rtd_c2t_pkg::*;

	localparam int ITEMS_PER_SETTING = 50;
	localparam int CORNER_ITEMS = 12;
	localparam int SETTINGS_PER_PHASE = 5;
	localparam int PIPE_SETTLE = 12;
	localparam int unsigned VOLT_OFFSET = 6554;
	localparam int unsigned DEFAULT_V_UPPER = 157286;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	rtd_in_t               in_item = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	rtd_out_t              out_item;

	int mismatches;
	int results_pending;
	int send_idle_pct = 10;
	int recv_idle_pct = 83;
	int readings_sent = 0;
	int settings_used = 0;
	rtd_cfg_t active;

	rtd_code_to_temperature dut (.*);

	rtd_code_to_temperature_checker conv_check (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	initial begin
		#2_000_000;
		$display("Timed out waiting for results.");
		$display("Mismatches found");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic load_settings(input rtd_cfg_t s);
		write_reg(CFG_FORMULA_MODE, CFG_DATA_W'(s.formula_mode));
		write_reg(CFG_ADC_LOW, CFG_DATA_W'(s.adc_low));
		write_reg(CFG_ADC_HIGH, CFG_DATA_W'(s.adc_high));
		write_reg(CFG_R_MIN, CFG_DATA_W'(s.r_min));
		write_reg(CFG_CODE_GAIN, s.code_gain);
		write_reg(CFG_SEG_WIDTH, CFG_DATA_W'(s.seg_width));
		write_reg(CFG_SEG_RECIP, s.seg_recip);
		write_reg(CFG_V_UPPER, CFG_DATA_W'(s.v_upper));
		active = s;
		settings_used++;
	endtask

	task automatic send_reading(input logic [11:0] code, input logic [17:0] volt);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{adc_code: code, voltage: volt};
		do @(posedge clk); while (!in_ready);
		readings_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	function automatic rtd_cfg_t pick_settings(int corner);
		rtd_cfg_t s;
		logic [63:0] recip;
		if (corner == 1) begin
			s = '1;
			return s;
		end
		if (corner == 2) begin
			s = '0;
			s.seg_width = 24'd1;
			return s;
		end
		s.formula_mode = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 3))
			0: begin
				s.adc_low = 12'($urandom_range(0, 200));
				s.adc_high = 12'($urandom_range(3800, 4095));
			end
			1: begin
				s.adc_low = 12'($urandom);
				s.adc_high = 12'($urandom);
			end
			2: begin
				s.adc_low = 12'd0;
				s.adc_high = 12'd4095;
			end
			default: begin
				s.adc_low = 12'($urandom_range(0, 2047));
				s.adc_high = s.adc_low + 12'($urandom_range(0, 2048));
			end
		endcase
		case ($urandom_range(0, 5))
			0, 1, 2: s.r_min = 24'($urandom_range(6000000, 7000000));
			3: s.r_min = 24'd0;
			4: s.r_min = 24'hFF_FFFF;
			default: s.r_min = 24'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0, 1, 2: s.code_gain = $urandom_range(300000, 600000);
			3: s.code_gain = 32'd0;
			4: s.code_gain = 32'hFFFF_FFFF;
			default: s.code_gain = $urandom;
		endcase
		case ($urandom_range(0, 5))
			0, 1, 2: begin
				s.seg_width = 24'($urandom_range(20000, 150000));
				recip = (64'd1 << 32) / 64'(s.seg_width);
				s.seg_recip = recip[31:0];
			end
			3: begin
				s.seg_width = 24'($urandom_range(1, 24'hFF_FFFF));
				recip = (64'd1 << 32) / 64'(s.seg_width);
				s.seg_recip = (recip > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : recip[31:0];
			end
			4: begin
				s.seg_width = $urandom_range(0, 1) ? 24'hFF_FFFF : 24'd1;
				s.seg_recip = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
			end
			default: begin
				s.seg_width = 24'($urandom_range(1, 24'hFF_FFFF));
				s.seg_recip = $urandom;
			end
		endcase
		case ($urandom_range(0, 5))
			0, 1, 2: s.v_upper = 18'($urandom_range(DEFAULT_V_UPPER - 50000,
				DEFAULT_V_UPPER + 80000));
			3: s.v_upper = 18'd0;
			4: s.v_upper = 18'h3_FFFF;
			default: s.v_upper = 18'($urandom);
		endcase
		return s;
	endfunction

	task automatic send_random_reading();
		int unsigned c;
		int unsigned v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: c = $urandom_range(active.adc_low, active.adc_high);
			6: c = 32'(active.adc_low);
			7: c = 32'(active.adc_high);
			8: c = $urandom_range(0, 1) ? active.adc_low - 1 : active.adc_high + 1;
			default: c = $urandom;
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: v = $urandom_range(VOLT_OFFSET, active.v_upper);
			6: v = VOLT_OFFSET;
			7: v = 32'(active.v_upper);
			8: v = $urandom_range(0, 1) ? VOLT_OFFSET - 1 : active.v_upper + 1;
			default: v = $urandom;
		endcase
		send_reading(c[11:0], v[17:0]);
	endtask

	initial begin
		int phase;
		int k;
		int n;
		int count;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Power-on settings: two-point mode over the full code range.
		send_reading(12'd0, 18'd0);
		send_reading(12'd1, 18'h3_FFFF);
		send_reading(12'd4095, 18'd0);
		send_reading(12'hAAA, 18'h2_AAAA);
		send_reading(12'h555, 18'h1_5555);

		drain();
		write_reg(CFG_ADC_LOW, 32'd100);
		write_reg(CFG_ADC_HIGH, 32'd3000);
		send_reading(12'd99, 18'd0);
		send_reading(12'd100, 18'd0);
		send_reading(12'd3000, 18'd0);
		send_reading(12'd3001, 18'd0);
		send_reading(12'd4095, 18'd0);

		drain();
		write_reg(CFG_FORMULA_MODE, 32'd1);
		send_reading(12'hFFF, 18'd0);
		send_reading(12'hFFF, 18'd6553);
		send_reading(12'd0, 18'd6554);
		send_reading(12'd0, 18'd157286);
		send_reading(12'd0, 18'd157287);
		send_reading(12'd0, 18'h3_FFFF);

		// Saturating resistance, zero segment width and capped fraction.
		drain();
		write_reg(CFG_FORMULA_MODE, 32'd0);
		write_reg(CFG_ADC_LOW, 32'd0);
		write_reg(CFG_ADC_HIGH, 32'd4095);
		write_reg(CFG_R_MIN, 32'd0);
		write_reg(CFG_CODE_GAIN, 32'hFFFF_FFFF);
		write_reg(CFG_SEG_WIDTH, 32'd0);
		write_reg(CFG_SEG_RECIP, 32'hFFFF_FFFF);
		send_reading(12'd0, 18'd0);
		send_reading(12'd4095, 18'd0);

		// A wide segment makes the remainder negative, and the index clamps.
		drain();
		write_reg(CFG_CODE_GAIN, 32'd256);
		write_reg(CFG_SEG_WIDTH, 32'hFF_FFFF);
		send_reading(12'd5, 18'd0);
		send_reading(12'd200, 18'd0);

		drain();
		write_reg(CFG_SEG_RECIP, 32'd0);
		send_reading(12'd300, 18'd0);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 10;
					recv_idle_pct = 83;
				end
				1: begin
					send_idle_pct = 83;
					recv_idle_pct = 10;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (k = 0; k < SETTINGS_PER_PHASE; k++) begin
				drain();
				load_settings(pick_settings((k == 0) ? phase : 0));
				count = (k == 0 && phase != 0) ? CORNER_ITEMS : ITEMS_PER_SETTING;
				for (n = 0; n < count; n++) begin
					if ($urandom_range(0, 63) == 0) begin
						drain();
					end
					send_random_reading();
				end
			end
		end

		drain();
		$display("Sent %0d readings under %0d full register settings plus directed corners,",
			readings_sent, settings_used);
		$display("covering both formulas, range limits, saturation and table clamping.");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/rtd_c2t_pkg.sv
rtl/core/rtd_c2t_res.sv
rtl/core/rtd_c2t_interp.sv
rtl/core/rtd_code_to_temperature.sv
verif/rtd_code_to_temperature_checker.sv
verif/rtd_code_to_temperature_tb.sv
